>>> hw/rtl/cism_pkg.sv
package cism_pkg;

    localparam int unsigned PATTERN_BYTES = 32;
    localparam int unsigned WORD_COUNT    = 4;
    localparam int unsigned WORD_BYTES    = 8;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned LEN_W         = 6;

    localparam logic [7:0] UPPER_A     = 8'd65;
    localparam logic [7:0] UPPER_Z     = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN   = 3'd0,
        CFG_PAT_A = 3'd1,
        CFG_PAT_B = 3'd2,
        CFG_PAT_C = 3'd3,
        CFG_PAT_D = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic adv;
        logic clr;
    } t_cell_ctl;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/case_insensitive_substring_match.sv
// Case-insensitive substring search over a byte stream.
// Input channel (i_in_valid / o_in_ready) carries one text byte per request,
// with i_end_of_text marking the last byte and i_empty_text standing for a
// whole empty text. Output channel (o_out_valid / i_out_ready) carries one
// o_found per finished text: on the request with i_end_of_text or i_empty_text
// set, o_found shows in the next cycle from an output register. Throughput is
// one byte per cycle unless stalled: a row of PATTERN_MAX match cells, one per
// pattern position, updates on every accepted byte, each taking its neighbor's
// partial match bit and comparing the new byte to its pattern byte. Write
// pattern registers via i_cfg_we / i_cfg_idx / i_cfg_data only while no text
// is in progress; the block does not enforce it. Reset clears pattern length,
// pattern bytes, cell state and the sticky hit flag. When the receiver stalls,
// the result holds in the output register and o_in_ready stays low, so no byte
// is taken meanwhile; a new byte is taken in the same cycle the result leaves.
module case_insensitive_substring_match
    import cism_pkg::*;
#(
    parameter int unsigned PATTERN_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_empty_text,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_found,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned ALW = $clog2(PATTERN_MAX + 1) > LEN_W ?
                                  $clog2(PATTERN_MAX + 1) : LEN_W;
    localparam int unsigned IW  = PATTERN_MAX > 1 ? $clog2(PATTERN_MAX) : 1;
    localparam logic [ALW-1:0] MAX_LEN = ALW'(PATTERN_MAX);

    logic [LEN_W-1:0]      r_len;
    logic [CFG_DATA_W-1:0] r_pat [WORD_COUNT];
    logic                  r_seen;
    logic                  r_out_valid;
    logic                  r_found;

    logic                   accept;
    logic                   done;
    t_cell_ctl              ctl;
    logic [7:0]             text_fold;
    logic [ALW-1:0]         act_len;
    logic [ALW-1:0]         last_pos;
    logic [IW-1:0]          sel;
    logic [PATTERN_MAX-1:0] match_vec;
    logic [PATTERN_MAX-1:0] next_vec;
    logic                   hit;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign done       = i_empty_text || i_end_of_text;
    assign ctl.adv    = accept;
    assign ctl.clr    = accept && done;
    assign text_fold  = fold_case(i_text_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int k = 0; k < WORD_COUNT; k++) begin
                r_pat[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEN:   r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_PAT_A: r_pat[0] <= i_cfg_data;
                CFG_PAT_B: r_pat[1] <= i_cfg_data;
                CFG_PAT_C: r_pat[2] <= i_cfg_data;
                CFG_PAT_D: r_pat[3] <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            logic [7:0] pat_byte;
            logic       prev;
            if (g < PATTERN_BYTES) begin : g_pat
                assign pat_byte = r_pat[g / WORD_BYTES][(g % WORD_BYTES) * 8 +: 8];
            end else begin : g_zero
                assign pat_byte = 8'd0;
            end
            if (g == 0) begin : g_first
                assign prev = 1'b1;
            end else begin : g_rest
                assign prev = match_vec[g-1];
            end
            cism_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_text  (text_fold),
                .i_pat   (pat_byte),
                .i_prev  (prev),
                .o_match (match_vec[g]),
                .o_next  (next_vec[g])
            );
        end
    endgenerate

    always_comb begin
        act_len  = (ALW'(r_len) > MAX_LEN) ? MAX_LEN : ALW'(r_len);
        last_pos = act_len - ALW'(1);
        sel      = last_pos[IW-1:0];
        hit      = (act_len != '0) && next_vec[sel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (accept) begin
                if (i_empty_text) begin
                    r_seen <= 1'b0;
                end else if (i_end_of_text) begin
                    r_seen <= 1'b0;
                end else begin
                    r_seen <= r_seen || hit;
                end
            end
            if (accept && done) begin
                r_out_valid <= 1'b1;
                r_found     <= !i_empty_text && (r_seen || hit);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && done) |=> (match_vec == '0 && !r_seen))
        else $error("cell state not cleared after end of text");

    a_result_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && done) |=> o_out_valid)
        else $error("no result after end of text");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !done) |=> (o_out_valid == $past(o_out_valid && !i_out_ready)))
        else $error("result appeared for a byte that ends no text");

    a_found_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (r_len != '0))
        else $error("match reported with empty pattern");

endmodule

>>> hw/rtl/cism_cell.sv
module cism_cell
    import cism_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic [7:0] i_text,
    input  logic [7:0] i_pat,
    input  logic      i_prev,
    output logic      o_match,
    output logic      o_next
);

    logic r_match;
    logic n_match;

    assign n_match = i_prev && (i_text == fold_case(i_pat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.clr) begin
            r_match <= 1'b0;
        end else if (i_ctl.adv) begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;
    assign o_next  = n_match;

endmodule

>>> dv/case_insensitive_substring_match_test.sv
module case_insensitive_substring_match_test;
    import cism_pkg::*;

    localparam int unsigned WIN          = PATTERN_BYTES;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 1030;
    localparam int          PHASES       = 9;

    typedef struct {
        bit          cfg;
        logic [5:0]  len;
        logic [63:0] word;
        logic [7:0]  b;
        bit          e;
        bit          t;
        bit          pin;
        bit          f;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte;
    logic                  i_empty_text;
    logic                  i_end_of_text;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_found;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic [5:0]   pat_len;
    logic [255:0] pat_bits;
    logic [7:0]   window [WIN];
    int unsigned  seen;
    bit           hit;

    bit found_q [$];
    int errors;
    int cycles;
    int send_idle_pct;
    int stall_pct;
    bit pin_en;
    bit pin_val;
    int items_sent;

    t_row script [23] = '{
        '{1'b0, 6'd0, 64'd0, "A",   1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b1, 6'd3, 64'h0000_0000_0000_4261, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "x",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "A",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "b",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "a",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "B",   1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 6'd0, 64'd0, "a",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "B",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0},
        '{1'b0, 6'd0, 64'd0, "A",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "b",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h01, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "a",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "b",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h20, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "a",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, "b",   1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 6'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1}
    };

    case_insensitive_substring_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_empty_text  (i_empty_text),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        return (is_letter(c) && $urandom_range(1) == 1) ? c ^ 8'h20 : c;
    endfunction

    function automatic int unsigned active_len();
        return (pat_len > WIN) ? WIN : pat_len;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned pos);
        return pat_bits[pos*8 +: 8];
    endfunction

    function automatic void clear_text();
        for (int i = 0; i < WIN; i++) window[i] = 8'd0;
        seen = 0;
        hit  = 1'b0;
    endfunction

    function automatic bit window_hit();
        int unsigned n;
        n = active_len();
        if (n == 0 || seen < n) return 1'b0;
        for (int j = 0; j < n; j++) begin
            if (to_lower(window[n-1-j]) != to_lower(pattern_at(j))) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_request(input logic [7:0] b, input logic e, input logic t,
                                            output bit has, output bit f);
        has = 1'b0;
        f   = 1'b0;
        if (e) begin
            clear_text();
            has = 1'b1;
        end else begin
            for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            if (seen < WIN) seen++;
            if (window_hit()) hit = 1'b1;
            if (t) begin
                has = 1'b1;
                f   = hit;
                clear_text();
            end
        end
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] odd [7];
        odd = '{8'h00, 8'hFF, 8'h40, 8'h60, 8'h5B, 8'h7B, 8'h20};
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1: return flip_case(pattern_at($urandom_range(WIN - 1)));
            2: return flip_case(8'd97 + 8'($urandom_range(25)));
            default: return odd[$urandom_range(6)];
        endcase
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        bit has;
        bit f;
        bit want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (found_q.size() == 0) begin
                    errors++;
                    $display("%0t: found expected none, got %0b", $time, o_found);
                end else begin
                    want = found_q.pop_front();
                    if (o_found !== want) begin
                        errors++;
                        $display("%0t: found expected %0b, got %0b", $time, want, o_found);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_request(i_text_byte, i_empty_text, i_end_of_text, has, f);
                if (has) found_q.push_back(pin_en ? pin_val : f);
            end
        end
    end

    task automatic push_request(input logic [7:0] b, input logic e, input logic t,
                                input bit pin, input bit f);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        pin_en = pin;
        pin_val = f;
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_empty_text  <= e;
        i_end_of_text <= t;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
            @(negedge i_clk);
        end
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (found_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_pattern(input logic [5:0] len, input logic [255:0] bytes);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LEN;
        i_cfg_data <= CFG_DATA_W'(len);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PAT_A;
        i_cfg_data <= bytes[63:0];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PAT_B;
        i_cfg_data <= bytes[127:64];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PAT_C;
        i_cfg_data <= bytes[191:128];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_PAT_D;
        i_cfg_data <= bytes[255:192];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pat_len  = len;
        pat_bits = bytes;
    endtask

    task automatic send_text();
        logic [7:0]  text [$];
        int unsigned plen;
        int          kind;
        int          k;
        plen = active_len();
        kind = $urandom_range(99);
        repeat ($urandom_range(4)) text.push_back(noise_byte());
        if (kind < 60 && plen > 0) begin
            for (int j = 0; j < plen; j++) text.push_back(flip_case(pattern_at(j)));
        end else if (kind < 80 && plen > 0) begin
            // byte k is corrupted, or dropped if last, or else kept
            k = $urandom_range(plen - 1);
            for (int j = 0; j < plen; j++) begin
                if (j != k) text.push_back(flip_case(pattern_at(j)));
                else if ($urandom_range(1) == 1) text.push_back(pattern_at(j) + 8'd1);
                else if (j != plen - 1) text.push_back(pattern_at(j));
            end
        end else begin
            repeat ($urandom_range(plen + 4, 1)) text.push_back(noise_byte());
        end
        repeat ($urandom_range(4)) text.push_back(noise_byte());
        if (text.size() == 0) text.push_back(noise_byte());

        kind = $urandom_range(19);
        if (kind == 0) begin
            push_request(noise_byte(), 1'b1, 1'($urandom_range(1)), 1'b0, 1'b0);
        end else if (kind == 1) begin
            // abandon the text halfway with an empty-text request
            for (int j = 0; j < (text.size() + 1) / 2; j++)
                push_request(text[j], 1'b0, 1'b0, 1'b0, 1'b0);
            push_request(noise_byte(), 1'b1, 1'($urandom_range(1)), 1'b0, 1'b0);
        end else begin
            for (int j = 0; j < text.size(); j++)
                push_request(text[j], 1'b0, j == text.size() - 1, 1'b0, 1'b0);
        end
    endtask

    initial begin
        logic [255:0] bytes;
        logic [5:0]   len;
        int           wmode;
        logic [7:0]   c;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_text_byte   = 8'd0;
        i_empty_text  = 1'b0;
        i_end_of_text = 1'b0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_LEN;
        i_cfg_data    = '0;
        pat_len       = 6'd0;
        pat_bits      = '0;
        errors        = 0;
        cycles        = 0;
        pin_en        = 1'b0;
        pin_val       = 1'b0;
        items_sent    = 0;
        send_idle_pct = 35;
        stall_pct     = 62;
        clear_text();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[r]) begin
            if (script[r].cfg) begin
                settle();
                load_pattern(script[r].len, {192'd0, script[r].word});
            end else begin
                push_request(script[r].b, script[r].e, script[r].t, script[r].pin, script[r].f);
            end
        end

        items_sent = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase / 3)
                0: begin send_idle_pct = 35; stall_pct = 62; end
                1: begin send_idle_pct = 62; stall_pct = 35; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            wmode = 0;
            case (phase)
                0: len = 6'd1;
                1: begin len = 6'd32; wmode = 1; end
                2: begin len = 6'd63; wmode = 2; end
                3: len = 6'd0;
                4: len = 6'($urandom_range(8, 2));
                5: len = 6'($urandom_range(31, 9));
                6: len = 6'd32;
                7: len = 6'd3;
                default: len = 6'($urandom_range(63));
            endcase
            for (int k = 0; k < WIN; k++) begin
                if (wmode == 1) c = 8'hFF;
                else if (wmode == 2) c = 8'h00;
                else if ($urandom_range(1) == 1) c = flip_case(8'd97 + 8'($urandom_range(25)));
                else c = 8'($urandom_range(255));
                bytes[k*8 +: 8] = c;
            end
            settle();
            load_pattern(len, bytes);
            while (items_sent < RANDOM_ITEMS / PHASES * (phase + 1)) send_text();
        end

        settle();
        repeat (6) @(negedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
